@@ design/b64d_pkg.sv @@
// Shared types, codes and the symbol lookup for the Base64 stream decoder.
// No dependencies; used by b64d_step and base64_stream_decoder_core.
package b64d_pkg;

   localparam int unsigned CAP_W   = 16;
   localparam int unsigned COUNT_W = 16;

   // Result kinds
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_FAIL = 2'd2;

   // Pad tracking codes
   localparam logic [1:0] PAD_NONE = 2'd0;
   localparam logic [1:0] PAD_HALF = 2'd1; // one '=' after two symbols, second required
   localparam logic [1:0] PAD_DONE = 2'd2;

   // Register indexes
   localparam logic CSR_OUTPUT_CAPACITY = 1'b0;
   localparam logic CSR_COUNT_ONLY      = 1'b1;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd256;
   localparam logic [7:0]       PAD_CHAR       = 8'h3D;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

   typedef struct packed {
      logic [7:0] symbol;
      logic       is_end;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         data_byte;
      logic [COUNT_W-1:0] length;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         quad_phase;
      logic [1:0]         pad_stage;
      logic               error_seen;
      logic [COUNT_W-1:0] byte_count;
      logic [7:0]         partial_byte;
   } state_type;

   // Bit 6 set: not in the alphabet. Otherwise bits 5:0 carry the sextet.
   function automatic logic [6:0] sym_value(input logic [7:0] c);
      logic [6:0] v;
      v = 7'h40;
      if (c inside {[8'h41:8'h5A]}) begin
         v = {1'b0, 6'(c - 8'h41)};
      end else if (c inside {[8'h61:8'h7A]}) begin
         v = {1'b0, 6'(c - 8'h47)};
      end else if (c inside {[8'h30:8'h39]}) begin
         v = {1'b0, 6'(c + 8'h04)};
      end else if (c == 8'h2B) begin
         v = 7'd62;
      end else if (c == 8'h2F) begin
         v = 7'd63;
      end
      return v;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
   endfunction

endpackage

@@ design/base64_stream_decoder_core.sv @@
// Top level of the streaming Base64 decoder: state, config and result registers.
// Depends on b64d_pkg and b64d_step.
//
//   channel  | ports                              | moves
//   ---------+------------------------------------+-------------------------------
//   request  | req_valid, req_ready, req_data     | one character or end mark per beat
//   response | rsp_valid, rsp_ready, rsp_data     | data byte, or final length/error
//   config   | csr_we, csr_index, csr_wdata       | capacity and count-only mode
//
// One character per cycle while req_ready is high: the decode state and any result
// are both registered at the accepting edge.
// req_ready is low only while a response sits unaccepted with rsp_ready low.
// Synchronous reset clears decode state, sets capacity to 256 and count-only off.
// An end beat always produces a response and returns the decode state to its reset value.
module base64_stream_decoder_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  b64d_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output b64d_pkg::rsp_type           rsp_data,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [b64d_pkg::CAP_W-1:0]  csr_wdata
);
   import b64d_pkg::*;

   state_type        state_ff, state_in;
   logic [CAP_W-1:0] capacity_ff;
   logic             count_only_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   rsp_type          step_rsp;
   logic             step_emit;
   logic             accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   b64d_step u_step (
      .req        (req_data),
      .cur        (state_ff),
      .capacity   (capacity_ff),
      .count_only (count_only_ff),
      .nxt        (state_in),
      .emit       (step_emit),
      .rsp        (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '0;
         capacity_ff   <= CAPACITY_RESET;
         count_only_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_OUTPUT_CAPACITY: capacity_ff   <= csr_wdata;
               CSR_COUNT_ONLY:      count_only_ff <= csr_wdata[0];
               default:             capacity_ff   <= capacity_ff;
            endcase
         end
         if (accept && step_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step_emit) begin
         rsp_data_ff <= step_rsp;
      end
   end

   // end beat leaves the decoder cleared
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.is_end |=> state_ff == '0)
      else $error("decode state not cleared after end beat");

   // count-only mode never produces a beat for a character
   a_count_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && !req_data.is_end && count_only_ff |=> !rsp_valid)
      else $error("response in count-only mode");

   // errors stick until the end beat
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      accept && !req_data.is_end && state_ff.error_seen |=> state_ff.error_seen)
      else $error("error flag dropped before end");

   // byte count only grows between end beats
   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      accept && !req_data.is_end |=> state_ff.byte_count >= $past(state_ff.byte_count))
      else $error("byte count went backwards");

endmodule

@@ design/b64d_step.sv @@
// Next-state and result logic for one character or end beat of the decoder.
// Depends on b64d_pkg (types, codes, sym_value, is_blank).
module b64d_step (
   input  b64d_pkg::req_type            req,
   input  b64d_pkg::state_type          cur,
   input  logic [b64d_pkg::CAP_W-1:0]   capacity,
   input  logic                         count_only,
   output b64d_pkg::state_type          nxt,
   output logic                         emit,
   output b64d_pkg::rsp_type            rsp
);
   import b64d_pkg::*;

   logic [6:0]       sv;
   logic [5:0]       v;
   logic             checking;
   logic             bad_end;
   logic [COUNT_W:0] need;
   logic [7:0]       out_byte;

   assign sv       = sym_value(req.symbol);
   assign v        = sv[5:0];
   assign checking = !count_only;
   assign bad_end  = cur.error_seen || (cur.pad_stage == PAD_HALF) ||
                     (cur.pad_stage == PAD_NONE && cur.quad_phase != 2'd0);
   // phases 1 and 2 check one byte ahead
   assign need = (cur.quad_phase == 2'd1 || cur.quad_phase == 2'd2) ?
                 {1'b0, cur.byte_count} + 1'b1 : {1'b0, cur.byte_count};

   always_comb begin
      nxt      = cur;
      emit     = 1'b0;
      out_byte = 8'h00;
      rsp      = '0;
      if (req.is_end) begin
         nxt      = '0;
         emit     = 1'b1;
         rsp.kind = bad_end ? KIND_FAIL : KIND_DONE;
         rsp.length = bad_end ? '0 : cur.byte_count;
      end else if (cur.error_seen || is_blank(req.symbol)) begin
         nxt = cur;
      end else if (cur.pad_stage == PAD_DONE) begin
         nxt.error_seen = 1'b1;
      end else if (cur.pad_stage == PAD_HALF) begin
         if (req.symbol == PAD_CHAR) begin
            nxt.pad_stage = PAD_DONE;
         end else begin
            nxt.error_seen = 1'b1;
         end
      end else if (req.symbol == PAD_CHAR) begin
         if (cur.quad_phase < 2'd2 || (checking && cur.partial_byte != 8'h00)) begin
            nxt.error_seen = 1'b1;
         end else begin
            nxt.pad_stage = (cur.quad_phase == 2'd2) ? PAD_HALF : PAD_DONE;
         end
      end else if (sv[6]) begin
         nxt.error_seen = 1'b1;
      end else if (checking && need >= {1'b0, capacity}) begin
         nxt.error_seen = 1'b1;
      end else begin
         case (cur.quad_phase)
            2'd0: begin
               nxt.partial_byte = {v, 2'b00};
               nxt.quad_phase   = 2'd1;
            end
            2'd1: begin
               out_byte         = cur.partial_byte | {6'h00, v[5:4]};
               nxt.partial_byte = {v[3:0], 4'h0};
               nxt.quad_phase   = 2'd2;
            end
            2'd2: begin
               out_byte         = cur.partial_byte | {4'h0, v[5:2]};
               nxt.partial_byte = {v[1:0], 6'h00};
               nxt.quad_phase   = 2'd3;
            end
            default: begin
               out_byte         = cur.partial_byte | {2'b00, v};
               nxt.partial_byte = 8'h00;
               nxt.quad_phase   = 2'd0;
            end
         endcase
         if (cur.quad_phase != 2'd0) begin
            if (cur.byte_count != COUNT_MAX) begin
               nxt.byte_count = cur.byte_count + 1'b1;
            end
            emit          = checking;
            rsp.kind      = KIND_DATA;
            rsp.data_byte = out_byte;
         end
      end
   end

endmodule
